>>> src/tgf_pkg.sv
// shared types and constants for the team grouped fifo
package tgf_pkg;

  localparam int REQ_W = 2;
  localparam int MEMBER_W = 8;
  localparam int TEAM_IN_W = 4;
  localparam int STATUS_W = 2;

  typedef enum logic [REQ_W-1:0] {
    REQ_ASSIGN  = 2'd0,
    REQ_ENQUEUE = 2'd1,
    REQ_DEQUEUE = 2'd2,
    REQ_CLEAR   = 2'd3
  } req_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE   = 2'd0,
    ST_POPPED = 2'd1,
    ST_EMPTY  = 2'd2,
    ST_FULL   = 2'd3
  } status_t;

  typedef struct packed {
    status_t               status;
    logic [MEMBER_W-1:0]   member;
  } res_t;

endpackage

>>> src/tgf_ram.sv
// generic single write, single read ram with registered read
module tgf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> src/tgf_fifo.sv
// two entry register fifo used on both sides of the execution unit
module tgf_fifo #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] din,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] dout,
  output logic             empty
);

  logic [WIDTH-1:0] slot [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       count;
  logic             do_push;
  logic             do_pop;

  assign full    = count == 2'd2;
  assign empty   = count == 2'd0;
  assign dout    = slot[rd_ptr];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot[wr_ptr] <= din;
    end
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (do_push && !do_pop) begin
        count <= count + 2'd1;
      end else if (do_pop && !do_push) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule

>>> src/tgf_front.sv
// front end: folds member and team numbers into range and queues requests
module tgf_front import tgf_pkg::*; #(
  parameter int NUM_TEAMS = 16,
  parameter int NUM_MEMBERS = 256
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           push,
  input  logic [REQ_W-1:0]               req_type,
  input  logic [MEMBER_W-1:0]            member_id,
  input  logic [TEAM_IN_W-1:0]           team_id,
  output logic                           q_full,
  input  logic                           cmd_take,
  output logic                           cmd_valid,
  output req_t                           cmd_req,
  output logic [$clog2(NUM_MEMBERS)-1:0] cmd_member,
  output logic [$clog2(NUM_TEAMS)-1:0]   cmd_team
);

  localparam int MW = $clog2(NUM_MEMBERS);
  localparam int TW = $clog2(NUM_TEAMS);
  localparam int QW = REQ_W + MW + TW;

  typedef logic [MW-1:0] mtab_t [2**MEMBER_W];
  typedef logic [TW-1:0] ttab_t [2**TEAM_IN_W];

  function automatic mtab_t build_mtab();
    mtab_t r;
    for (int i = 0; i < 2**MEMBER_W; i++) begin
      r[i] = MW'(i % NUM_MEMBERS);
    end
    return r;
  endfunction

  function automatic ttab_t build_ttab();
    ttab_t r;
    for (int i = 0; i < 2**TEAM_IN_W; i++) begin
      r[i] = TW'(i % NUM_TEAMS);
    end
    return r;
  endfunction

  localparam mtab_t MTAB = build_mtab();
  localparam ttab_t TTAB = build_ttab();

  logic [QW-1:0] q_din;
  logic [QW-1:0] q_dout;
  logic          q_empty;

  // numbers out of range wrap before they are queued
  assign q_din = {req_type, MTAB[member_id], TTAB[team_id]};

  tgf_fifo #(.WIDTH(QW)) u_req_q (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .din   (q_din),
    .full  (q_full),
    .pop   (cmd_take),
    .dout  (q_dout),
    .empty (q_empty)
  );

  assign cmd_valid  = !q_empty;
  assign cmd_req    = req_t'(q_dout[QW-1 -: REQ_W]);
  assign cmd_member = q_dout[TW +: MW];
  assign cmd_team   = q_dout[TW-1:0];

endmodule

>>> src/tgf_back.sv
// back end: sequencer that walks the linked lists in the state rams
module tgf_back import tgf_pkg::*; #(
  parameter int NUM_TEAMS = 16,
  parameter int NUM_MEMBERS = 256,
  parameter int QUEUE_ENTRIES = 64
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cmd_valid,
  input  req_t                           cmd_req,
  input  logic [$clog2(NUM_MEMBERS)-1:0] cmd_member,
  input  logic [$clog2(NUM_TEAMS)-1:0]   cmd_team,
  output logic                           cmd_take,
  output logic                           boot,
  output logic                           res_push,
  output res_t                           res,
  input  logic                           res_full
);

  localparam int MW = $clog2(NUM_MEMBERS);
  localparam int TW = $clog2(NUM_TEAMS);
  localparam int SW = $clog2(QUEUE_ENTRIES);
  localparam int FW = $clog2(QUEUE_ENTRIES + 1);
  localparam int OCW = $clog2(NUM_TEAMS + 1);
  localparam int SWEEP_N = (NUM_MEMBERS > NUM_TEAMS) ? NUM_MEMBERS : NUM_TEAMS;
  localparam int CW = $clog2(SWEEP_N);

  typedef enum logic [2:0] {
    S_SWEEP, S_IDLE, S_E_TEAM, S_E_LINK, S_D_TEAM, S_D_SLOT, S_D_FIN, S_RESP
  } state_t;

  state_t        state;
  logic          resp_pend;
  logic [CW-1:0] cnt;
  logic [FW-1:0] fresh;
  logic [FW-1:0] sp;
  logic [TW-1:0] ohead;
  logic [TW-1:0] otail;
  logic [OCW-1:0] ocount;
  logic [TW-1:0] t_r;
  logic [MW-1:0] m_r;
  logic [SW-1:0] slot_r;
  logic          last_r;
  logic          fresh_full;
  logic [FW-1:0] sp_dec;

  logic          tom_we;
  logic [MW-1:0] tom_waddr, tom_raddr;
  logic [TW-1:0] tom_wdata, tom_rd;
  logic          wait_we, wait_wdata, wait_rd;
  logic [TW-1:0] wait_waddr, wait_raddr;
  logic          head_we, tail_we;
  logic [TW-1:0] head_waddr, head_raddr, tail_waddr, tail_raddr;
  logic [SW-1:0] head_wdata, head_rd, tail_wdata, tail_rd;
  logic          order_we;
  logic [TW-1:0] order_wdata, order_rd;
  logic          emem_we;
  logic [SW-1:0] emem_waddr, emem_raddr;
  logic [MEMBER_W-1:0] emem_wdata, emem_rd;
  logic          enext_we;
  logic [SW-1:0] enext_waddr, enext_raddr, enext_wdata, enext_rd;
  logic          stack_we;
  logic [SW-1:0] stack_waddr, stack_raddr, stack_wdata, stack_rd;

  function automatic logic [TW-1:0] team_inc(input logic [TW-1:0] x);
    return (x == TW'(NUM_TEAMS - 1)) ? '0 : x + 1'b1;
  endfunction

  assign fresh_full = fresh == FW'(QUEUE_ENTRIES);
  assign sp_dec     = sp - 1'b1;
  assign cmd_take   = (state == S_IDLE) && cmd_valid;
  assign res_push   = (state == S_RESP) && !res_full;

  always_comb begin
    tom_we = 1'b0;       tom_waddr = cnt[MW-1:0]; tom_wdata = '0; tom_raddr = cmd_member;
    wait_we = 1'b0;      wait_waddr = cnt[TW-1:0]; wait_wdata = 1'b0; wait_raddr = tom_rd;
    head_we = 1'b0;      head_waddr = t_r; head_wdata = slot_r; head_raddr = order_rd;
    tail_we = 1'b0;      tail_waddr = t_r; tail_wdata = slot_r; tail_raddr = tom_rd;
    order_we = 1'b0;     order_wdata = t_r;
    emem_we = 1'b0;      emem_waddr = slot_r; emem_wdata = MEMBER_W'(m_r); emem_raddr = head_rd;
    enext_we = 1'b0;     enext_waddr = tail_rd; enext_wdata = slot_r; enext_raddr = head_rd;
    stack_we = 1'b0;     stack_waddr = sp[SW-1:0]; stack_wdata = slot_r;
    stack_raddr = sp_dec[SW-1:0];
    case (state)
      S_SWEEP: begin
        tom_we  = 1'b1;
        wait_we = 1'b1;
      end
      S_IDLE: begin
        if (cmd_valid && cmd_req == REQ_ASSIGN) begin
          tom_we    = 1'b1;
          tom_waddr = cmd_member;
          tom_wdata = cmd_team;
        end
      end
      S_D_TEAM: begin
        tail_raddr = order_rd;
      end
      S_E_LINK: begin
        emem_we = 1'b1;
        tail_we = 1'b1;
        if (wait_rd) begin
          enext_we = 1'b1;
        end else begin
          wait_we    = 1'b1;
          wait_waddr = t_r;
          wait_wdata = 1'b1;
          head_we    = 1'b1;
          order_we   = 1'b1;
        end
      end
      S_D_FIN: begin
        stack_we = 1'b1;
        if (last_r) begin
          wait_we    = 1'b1;
          wait_waddr = t_r;
        end else begin
          head_we    = 1'b1;
          head_wdata = enext_rd;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_SWEEP;
      boot      <= 1'b1;
      resp_pend <= 1'b0;
      cnt       <= '0;
      fresh     <= '0;
      sp        <= '0;
      ohead     <= '0;
      otail     <= '0;
      ocount    <= '0;
    end else begin
      case (state)
        S_SWEEP: begin
          if (cnt == CW'(SWEEP_N - 1)) begin
            boot      <= 1'b0;
            resp_pend <= 1'b0;
            state     <= resp_pend ? S_RESP : S_IDLE;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        S_IDLE: begin
          if (cmd_valid) begin
            m_r <= cmd_member;
            t_r <= cmd_team;
            case (cmd_req)
              REQ_ASSIGN: begin
                res   <= '{status: ST_DONE, member: '0};
                state <= S_RESP;
              end
              REQ_CLEAR: begin
                res       <= '{status: ST_DONE, member: '0};
                fresh     <= '0;
                sp        <= '0;
                ohead     <= '0;
                otail     <= '0;
                ocount    <= '0;
                cnt       <= '0;
                resp_pend <= 1'b1;
                state     <= S_SWEEP;
              end
              REQ_ENQUEUE: begin
                if (fresh_full && sp == '0) begin
                  res   <= '{status: ST_FULL, member: '0};
                  state <= S_RESP;
                end else begin
                  res   <= '{status: ST_DONE, member: '0};
                  state <= S_E_TEAM;
                end
              end
              REQ_DEQUEUE: begin
                if (ocount == '0) begin
                  res   <= '{status: ST_EMPTY, member: '0};
                  state <= S_RESP;
                end else begin
                  state <= S_D_TEAM;
                end
              end
              default: state <= S_IDLE;
            endcase
          end
        end
        S_E_TEAM: begin
          t_r    <= tom_rd;
          slot_r <= fresh_full ? stack_rd : fresh[SW-1:0];
          state  <= S_E_LINK;
        end
        S_E_LINK: begin
          if (fresh_full) begin
            sp <= sp_dec;
          end else begin
            fresh <= fresh + 1'b1;
          end
          if (!wait_rd) begin
            otail  <= team_inc(otail);
            ocount <= ocount + 1'b1;
          end
          state <= S_RESP;
        end
        S_D_TEAM: begin
          t_r   <= order_rd;
          state <= S_D_SLOT;
        end
        S_D_SLOT: begin
          slot_r <= head_rd;
          last_r <= tail_rd == head_rd;
          state  <= S_D_FIN;
        end
        S_D_FIN: begin
          sp  <= sp + 1'b1;
          res <= '{status: ST_POPPED, member: emem_rd};
          if (last_r) begin
            ohead  <= team_inc(ohead);
            ocount <= ocount - 1'b1;
          end
          state <= S_RESP;
        end
        S_RESP: begin
          if (!res_full) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  tgf_ram #(.WIDTH(TW), .DEPTH(NUM_MEMBERS)) u_team_of_member (
    .clk(clk), .we(tom_we), .waddr(tom_waddr), .wdata(tom_wdata),
    .raddr(tom_raddr), .rdata(tom_rd));

  tgf_ram #(.WIDTH(1), .DEPTH(NUM_TEAMS)) u_team_waiting (
    .clk(clk), .we(wait_we), .waddr(wait_waddr), .wdata(wait_wdata),
    .raddr(wait_raddr), .rdata(wait_rd));

  tgf_ram #(.WIDTH(SW), .DEPTH(NUM_TEAMS)) u_team_head (
    .clk(clk), .we(head_we), .waddr(head_waddr), .wdata(head_wdata),
    .raddr(head_raddr), .rdata(head_rd));

  tgf_ram #(.WIDTH(SW), .DEPTH(NUM_TEAMS)) u_team_tail (
    .clk(clk), .we(tail_we), .waddr(tail_waddr), .wdata(tail_wdata),
    .raddr(tail_raddr), .rdata(tail_rd));

  tgf_ram #(.WIDTH(TW), .DEPTH(NUM_TEAMS)) u_team_order (
    .clk(clk), .we(order_we), .waddr(otail), .wdata(order_wdata),
    .raddr(ohead), .rdata(order_rd));

  tgf_ram #(.WIDTH(MEMBER_W), .DEPTH(QUEUE_ENTRIES)) u_entry_member (
    .clk(clk), .we(emem_we), .waddr(emem_waddr), .wdata(emem_wdata),
    .raddr(emem_raddr), .rdata(emem_rd));

  tgf_ram #(.WIDTH(SW), .DEPTH(QUEUE_ENTRIES)) u_entry_next (
    .clk(clk), .we(enext_we), .waddr(enext_waddr), .wdata(enext_wdata),
    .raddr(enext_raddr), .rdata(enext_rd));

  tgf_ram #(.WIDTH(SW), .DEPTH(QUEUE_ENTRIES)) u_free_stack (
    .clk(clk), .we(stack_we), .waddr(stack_waddr), .wdata(stack_wdata),
    .raddr(stack_raddr), .rdata(stack_rd));

endmodule

>>> src/team_grouped_fifo_unit.sv
// top level of the team grouped fifo: request queue, sequencer, result queue
// a request walks the sequencer states of its kind (assign, enqueue or dequeue),
// set by the registered-read ram steps of the list walk; clear runs a clearing
// pass over max of NUM_MEMBERS and NUM_TEAMS entries
// rst is synchronous; after it a clearing pass over max(NUM_MEMBERS, NUM_TEAMS) entries holds full high
module team_grouped_fifo_unit import tgf_pkg::*; #(
  parameter int NUM_TEAMS = 16,
  parameter int NUM_MEMBERS = 256,
  parameter int QUEUE_ENTRIES = 64
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  output logic                 full,
  input  logic [REQ_W-1:0]     req_type,
  input  logic [MEMBER_W-1:0]  member_id,
  input  logic [TEAM_IN_W-1:0] team_id,
  output logic                 empty,
  input  logic                 pop,
  output logic [STATUS_W-1:0]  status,
  output logic [MEMBER_W-1:0]  member_out
);

  localparam int MW = $clog2(NUM_MEMBERS);
  localparam int TW = $clog2(NUM_TEAMS);

  // front to back request channel
  logic          q_full;
  logic          cmd_valid;
  logic          cmd_take;
  req_t          cmd_req;
  logic [MW-1:0] cmd_member;
  logic [TW-1:0] cmd_team;

  // back to result queue
  logic boot;
  logic res_push;
  logic res_full;
  res_t res;
  res_t res_head;

  // no beat taken while the post reset clearing pass runs
  assign full = q_full || boot;

  tgf_front #(
    .NUM_TEAMS   (NUM_TEAMS),
    .NUM_MEMBERS (NUM_MEMBERS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .push       (push && !full),
    .req_type   (req_type),
    .member_id  (member_id),
    .team_id    (team_id),
    .q_full     (q_full),
    .cmd_take   (cmd_take),
    .cmd_valid  (cmd_valid),
    .cmd_req    (cmd_req),
    .cmd_member (cmd_member),
    .cmd_team   (cmd_team)
  );

  tgf_back #(
    .NUM_TEAMS     (NUM_TEAMS),
    .NUM_MEMBERS   (NUM_MEMBERS),
    .QUEUE_ENTRIES (QUEUE_ENTRIES)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .cmd_valid  (cmd_valid),
    .cmd_req    (cmd_req),
    .cmd_member (cmd_member),
    .cmd_team   (cmd_team),
    .cmd_take   (cmd_take),
    .boot       (boot),
    .res_push   (res_push),
    .res        (res),
    .res_full   (res_full)
  );

  // result queue lets the sequencer finish while the consumer stalls
  tgf_fifo #(.WIDTH($bits(res_t))) u_res_q (
    .clk   (clk),
    .rst   (rst),
    .push  (res_push),
    .din   (res),
    .full  (res_full),
    .pop   (pop),
    .dout  (res_head),
    .empty (empty)
  );

  assign status     = res_head.status;
  assign member_out = res_head.member;

endmodule

>>> src/tgf_checker.sv
// port level checks for the team grouped fifo, bound to the top level
module tgf_checker import tgf_pkg::*; (
  input logic                clk,
  input logic                rst,
  input logic                full,
  input logic                empty,
  input logic                pop,
  input logic [STATUS_W-1:0] status,
  input logic [MEMBER_W-1:0] member_out
);

  // clearing pass blocks input right after reset
  a_boot_full: assert property (@(posedge clk) $fell(rst) |-> full)
    else $error("input open right after reset");

  // no result can be ready right after reset
  a_boot_empty: assert property (@(posedge clk) $fell(rst) |-> empty)
    else $error("result present right after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    !empty && !pop |=> !empty && $stable(status) && $stable(member_out))
    else $error("waiting result changed");

  a_member_zero: assert property (@(posedge clk) disable iff (rst)
    !empty && status != ST_POPPED |-> member_out == '0)
    else $error("member set on a non pop result");

endmodule

bind team_grouped_fifo_unit tgf_checker u_tgf_checker (.*);

>>> bench/team_grouped_fifo_unit_tb.sv
// testbench for the team grouped fifo: random and directed requests checked against a predictor
`timescale 1ns / 100ps

module team_grouped_fifo_unit_tb;
  import tgf_pkg::*;

  localparam int TEAMS = 16;
  localparam int MEMBERS = 256;
  localparam int ENTRIES = 64;

  typedef struct packed {
    req_t                 req;
    logic [MEMBER_W-1:0]  member;
    logic [TEAM_IN_W-1:0] team;
  } request_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic push = 1'b0;
  logic pop = 1'b0;
  logic [REQ_W-1:0] req_type = '0;
  logic [MEMBER_W-1:0] member_id = '0;
  logic [TEAM_IN_W-1:0] team_id = '0;
  logic full, empty;
  logic [STATUS_W-1:0] status;
  logic [MEMBER_W-1:0] member_out;

  team_grouped_fifo_unit dut (
    .clk(clk), .rst(rst), .push(push), .full(full),
    .req_type(req_type), .member_id(member_id), .team_id(team_id),
    .empty(empty), .pop(pop), .status(status), .member_out(member_out)
  );

  // clock; reset is held until the stimulus block releases it
  initial begin
    forever #6 clk = ~clk;
  end

  // shadow state: team membership plus one member queue per team and the team order
  logic [3:0] member_team [MEMBERS];
  logic [7:0] team_line [TEAMS][$];
  logic [3:0] team_turns [$];
  int         slots_used;

  request_t pending_reqs [$];
  res_t     expected_res [$];
  int       mismatches = 0;
  bit       stim_done = 1'b0;

  function automatic void wipe_teams();
    foreach (member_team[i]) member_team[i] = '0;
    foreach (team_line[t]) team_line[t].delete();
    team_turns.delete();
    slots_used = 0;
  endfunction

  // next result for one accepted request
  function automatic res_t predict_team_queue(request_t r);
    res_t o;
    logic [3:0] t;
    o.status = ST_DONE;
    o.member = '0;
    case (r.req)
      REQ_ASSIGN: member_team[r.member] = r.team;
      REQ_ENQUEUE: begin
        t = member_team[r.member];
        if (slots_used >= ENTRIES) o.status = ST_FULL;
        else begin
          // a team with no one waiting goes to the back of the team order
          if (team_line[t].size() == 0) team_turns.push_back(t);
          team_line[t].push_back(r.member);
          slots_used++;
        end
      end
      REQ_DEQUEUE: begin
        if (team_turns.size() == 0) o.status = ST_EMPTY;
        else begin
          t = team_turns[0];
          o.status = ST_POPPED;
          o.member = team_line[t].pop_front();
          slots_used--;
          // retire the front team once its line runs dry
          if (team_line[t].size() == 0) void'(team_turns.pop_front());
        end
      end
      default: wipe_teams();
    endcase
    return o;
  endfunction

  function automatic request_t mk(req_t q, int m, int t);
    request_t r;
    r.req = q;
    r.member = m[7:0];
    r.team = t[3:0];
    return r;
  endfunction

  // gap length: mostly none or short, now and then long
  function automatic int gap_len();
    int p;
    p = $urandom_range(99);
    if (p < 55) return 0;
    if (p < 92) return $urandom_range(3, 1);
    return $urandom_range(30, 8);
  endfunction

  // stimulus: directed corners then random scenarios
  initial begin
    int n, k, pool;
    wipe_teams();
    // dequeue on empty, extremes of fields, assign, enqueue and dequeue requests
    pending_reqs.push_back(mk(REQ_DEQUEUE, 8'hff, 4'hf));
    pending_reqs.push_back(mk(REQ_ENQUEUE, 0, 0));
    pending_reqs.push_back(mk(REQ_ASSIGN, 255, 15));
    pending_reqs.push_back(mk(REQ_ASSIGN, 0, 15));
    pending_reqs.push_back(mk(REQ_ENQUEUE, 255, 0));
    pending_reqs.push_back(mk(REQ_ENQUEUE, 7, 0));
    // assign while queued: member 7 queued in team 0 stays there
    pending_reqs.push_back(mk(REQ_ENQUEUE, 0, 0));
    pending_reqs.push_back(mk(REQ_ASSIGN, 7, 9));
    pending_reqs.push_back(mk(REQ_ENQUEUE, 7, 0));
    for (int i = 0; i < 6; i++) pending_reqs.push_back(mk(REQ_DEQUEUE, 0, 0));
    pending_reqs.push_back(mk(REQ_CLEAR, 8'haa, 4'h5));
    pending_reqs.push_back(mk(REQ_ENQUEUE, 255, 0));
    pending_reqs.push_back(mk(REQ_DEQUEUE, 0, 0));
    // full: 64 accepted, then drops
    for (int i = 0; i < 66; i++) pending_reqs.push_back(mk(REQ_ENQUEUE, i, 0));
    pending_reqs.push_back(mk(REQ_DEQUEUE, 0, 0));
    pending_reqs.push_back(mk(REQ_ENQUEUE, 200, 0));
    pending_reqs.push_back(mk(REQ_CLEAR, 0, 0));
    // random scenarios: assignments, then mixed enqueue/dequeue/assign, sometimes a clear
    n = 0;
    while (n < 1300) begin
      pool = $urandom_range(3) == 0 ? 256 : $urandom_range(24, 4);
      k = $urandom_range(12, 2);
      for (int i = 0; i < k; i++)
        pending_reqs.push_back(mk(REQ_ASSIGN, $urandom_range(pool - 1), $urandom_range(15)));
      n += k;
      k = $urandom_range(120, 10);
      for (int i = 0; i < k; i++) begin
        int p;
        p = $urandom_range(99);
        if (p < 52) pending_reqs.push_back(mk(REQ_ENQUEUE, $urandom_range(pool - 1),
                                              $urandom_range(15)));
        else if (p < 92) pending_reqs.push_back(mk(REQ_DEQUEUE, $urandom, $urandom));
        else if (p < 99) pending_reqs.push_back(mk(REQ_ASSIGN, $urandom_range(pool - 1),
                                                   $urandom_range(15)));
        else pending_reqs.push_back(mk(REQ_CLEAR, $urandom, $urandom));
      end
      n += k;
      if ($urandom_range(2) == 0) pending_reqs.push_back(mk(REQ_CLEAR, $urandom, $urandom));
      n++;
    end
    repeat (7) @(posedge clk);
    rst <= 1'b0;
  end

  // driver: one beat per accept, random gaps between beats
  int send_gap = 0;
  always @(posedge clk) begin
    if (!rst) begin
      if (push && !full) begin
        expected_res.push_back(predict_team_queue(pending_reqs.pop_front()));
        send_gap = gap_len();
      end
      if (!(push && full)) begin
        if (send_gap > 0) begin
          send_gap--;
          push <= 1'b0;
        end else if (pending_reqs.size() > 0) begin
          push <= 1'b1;
          req_type <= pending_reqs[0].req;
          member_id <= pending_reqs[0].member;
          team_id <= pending_reqs[0].team;
        end else begin
          push <= 1'b0;
          stim_done = 1'b1;
        end
      end
    end
  end

  // monitor: random stalls on pop, compare each beat with the oldest expectation
  int pop_gap = 0;
  always @(posedge clk) begin
    if (!rst) begin
      if (pop && !empty) begin
        pop_gap = gap_len();
        if (expected_res.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected beat: status %0d member %0d", status, member_out);
        end else begin
          res_t e;
          e = expected_res.pop_front();
          if (status !== e.status || member_out !== e.member) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected status %0d member %0d, got status %0d member %0d",
                       e.status, e.member, status, member_out);
          end
        end
      end
      if (pop_gap > 0) begin
        pop_gap--;
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  // end of run: drain, then a short settle
  initial begin
    wait (!rst);
    wait (stim_done && pending_reqs.size() == 0 && !push && expected_res.size() == 0);
    repeat (300) @(posedge clk);
    if (mismatches == 0 && expected_res.size() == 0)
      $display("PASS team_grouped_fifo_unit");
    else
      $display("FAIL team_grouped_fifo_unit");
    $finish;
  end

  // watchdog
  initial begin
    #8000000;
    $display("FAIL team_grouped_fifo_unit");
    $finish;
  end

endmodule
